// ===== hdl/tcp_frame_classifier_defines.svh =====
// Assertion macros for the TCP frame classifier RTL.
// Needs signals clk and rst_n in the scope of each use.
`ifndef TCP_FRAME_CLASSIFIER_DEFINES_SVH
`define TCP_FRAME_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define TFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TFC_ASSERT_IMP(lbl, ante, cons, msg)
`define TFC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/tfc_pkg.sv =====
// Shared types and constants of the TCP frame classifier.
// No dependencies.
`default_nettype none
package tfc_pkg;

  localparam logic [7:0]  ETH_LEN        = 8'd14;
  localparam logic [7:0]  IP_MIN_LEN     = 8'd20;
  localparam logic [7:0]  TCP_MIN_LEN    = 8'd20;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'h06;
  localparam int          FLAG_FIN_BIT   = 0;
  localparam int          FLAG_SYN_BIT   = 1;
  localparam int          FLAG_ACK_BIT   = 4;

  localparam logic [31:0] DEF_LOCAL_IP     = 32'd0;
  localparam logic [15:0] DEF_SERVICE_PORT = 16'd6379;
  localparam logic [7:0]  DEF_LEAD_IN      = 8'd10;

  localparam logic [1:0] REG_LOCAL_IP     = 2'd0;
  localparam logic [1:0] REG_SERVICE_PORT = 2'd1;
  localparam logic [1:0] REG_LEAD_IN      = 2'd2;

  localparam logic [3:0] VERDICT_SHORT    = 4'd0;
  localparam logic [3:0] VERDICT_NOT_IPV4 = 4'd1;
  localparam logic [3:0] VERDICT_BAD_IP   = 4'd2;
  localparam logic [3:0] VERDICT_NOT_TCP  = 4'd3;
  localparam logic [3:0] VERDICT_BAD_PORT = 4'd4;
  localparam logic [3:0] VERDICT_SYN      = 4'd5;
  localparam logic [3:0] VERDICT_FIN      = 4'd6;
  localparam logic [3:0] VERDICT_ACK      = 4'd7;
  localparam logic [3:0] VERDICT_NOFLAG   = 4'd8;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [15:0] service_port;
    logic [7:0]  lead_in_bytes;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ether_kind;
    logic [3:0]  header_words;
    logic [7:0]  ip_protocol;
    logic [31:0] dest_address;
    logic [15:0] src_port_seen;
    logic [15:0] dst_port_seen;
    logic [3:0]  tcp_words;
    logic [7:0]  tcp_flag_bits;
  } frame_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic        handled;
    logic [15:0] source_port;
    logic        payload_valid;
    logic [15:0] payload_start;
    logic [15:0] payload_length;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/tfc_regs.sv =====
// APB-style configuration registers of the TCP frame classifier.
// Depends on tfc_pkg.
`default_nettype none
module tfc_regs
  import tfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output cfg_t             cfg_o
);

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_LOCAL_IP:     cfg_nxt.local_ip      = pwdata;
        REG_SERVICE_PORT: cfg_nxt.service_port  = pwdata[15:0];
        REG_LEAD_IN:      cfg_nxt.lead_in_bytes = pwdata[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOCAL_IP:     prdata = cfg_r.local_ip;
      REG_SERVICE_PORT: prdata = {16'd0, cfg_r.service_port};
      REG_LEAD_IN:      prdata = {24'd0, cfg_r.lead_in_bytes};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_ip      <= DEF_LOCAL_IP;
      cfg_r.service_port  <= DEF_SERVICE_PORT;
      cfg_r.lead_in_bytes <= DEF_LEAD_IN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule
`default_nettype wire

// ===== hdl/tfc_capture.sv =====
// Byte counter and header field capture for the TCP frame classifier.
// Depends on tfc_pkg; gives the frame fields as they stand after the current byte.
`default_nettype none
module tfc_capture
  import tfc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [7:0]            frame_byte,
  input  wire logic                  last_byte,
  input  wire logic [7:0]            lead_in_bytes,
  output frame_t                     frame_o,
  output logic      [COUNT_BITS-1:0] count_o
);

  localparam int WW = (COUNT_BITS >= 16) ? COUNT_BITS + 1 : 17;

  frame_t                frame_r, frame_nxt, cap;
  logic [COUNT_BITS-1:0] count_r, count_nxt, count_upd;
  logic                  sat;
  logic [WW-1:0]         pos, ipb, tcp_base;
  logic [3:0]            ihl;

  assign sat = &count_r;
  assign pos = WW'(count_r);
  assign ipb = WW'(lead_in_bytes) + WW'(ETH_LEN);
  assign ihl = (pos == ipb) ? frame_byte[3:0] : frame_r.header_words;
  assign tcp_base = ipb + WW'({ihl, 2'b00});

  always_comb begin
    cap = frame_r;
    if (!sat) begin
      if (pos == ipb - WW'(2) || pos == ipb - WW'(1)) begin
        cap.ether_kind = {frame_r.ether_kind[7:0], frame_byte};
      end
      if (pos == ipb) begin
        cap.header_words = frame_byte[3:0];
      end
      if (pos == ipb + WW'(9)) begin
        cap.ip_protocol = frame_byte;
      end
      if (pos >= ipb + WW'(16) && pos <= ipb + WW'(19)) begin
        cap.dest_address = {frame_r.dest_address[23:0], frame_byte};
      end
      // TCP fields follow the IP header, which may overlap it for a small IHL
      if (pos >= ipb) begin
        if (pos == tcp_base || pos == tcp_base + WW'(1)) begin
          cap.src_port_seen = {frame_r.src_port_seen[7:0], frame_byte};
        end
        if (pos == tcp_base + WW'(2) || pos == tcp_base + WW'(3)) begin
          cap.dst_port_seen = {frame_r.dst_port_seen[7:0], frame_byte};
        end
        if (pos == tcp_base + WW'(12)) begin
          cap.tcp_words = frame_byte[7:4];
        end
        if (pos == tcp_base + WW'(13)) begin
          cap.tcp_flag_bits = frame_byte;
        end
      end
    end
  end

  // hold the count once saturated
  assign count_upd = sat ? count_r : count_r + 1'b1;

  always_comb begin
    frame_nxt = frame_r;
    count_nxt = count_r;
    if (step) begin
      if (last_byte) begin
        frame_nxt = '0;
        count_nxt = '0;
      end else begin
        frame_nxt = cap;
        count_nxt = count_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
      count_r <= '0;
    end else begin
      frame_r <= frame_nxt;
      count_r <= count_nxt;
    end
  end

  assign frame_o = cap;
  assign count_o = count_upd;

endmodule
`default_nettype wire

// ===== hdl/tfc_verdict.sv =====
// Verdict and payload bounds of one finished frame.
// Depends on tfc_pkg; pure combinational logic.
`default_nettype none
module tfc_verdict
  import tfc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire cfg_t                  cfg,
  input  wire frame_t                frame,
  input  wire logic [COUNT_BITS-1:0] frame_len,
  output result_t                    result
);

  localparam int WW = (COUNT_BITS >= 16) ? COUNT_BITS + 1 : 17;

  logic [WW-1:0] size, ipb, tcpb, hdr_end, pay_len;
  logic [3:0]    verdict;
  logic          pvalid;

  assign size    = WW'(frame_len);
  assign ipb     = WW'(cfg.lead_in_bytes) + WW'(ETH_LEN);
  assign tcpb    = ipb + WW'({frame.header_words, 2'b00});
  assign hdr_end = tcpb + WW'({frame.tcp_words, 2'b00});
  assign pay_len = size - hdr_end;

  always_comb begin
    if (size < ipb) begin
      verdict = VERDICT_SHORT;
    end else if (frame.ether_kind != ETHERTYPE_IPV4) begin
      verdict = VERDICT_NOT_IPV4;
    end else if (size < ipb + WW'(IP_MIN_LEN)) begin
      verdict = VERDICT_SHORT;
    end else if (frame.dest_address != cfg.local_ip) begin
      verdict = VERDICT_BAD_IP;
    end else if (frame.ip_protocol != PROTO_TCP) begin
      verdict = VERDICT_NOT_TCP;
    end else if (size < tcpb + WW'(TCP_MIN_LEN)) begin
      verdict = VERDICT_SHORT;
    end else if (frame.dst_port_seen != cfg.service_port) begin
      verdict = VERDICT_BAD_PORT;
    end else if (frame.tcp_flag_bits[FLAG_SYN_BIT]) begin
      verdict = VERDICT_SYN;
    end else if (frame.tcp_flag_bits[FLAG_FIN_BIT]) begin
      verdict = VERDICT_FIN;
    end else if (frame.tcp_flag_bits[FLAG_ACK_BIT]) begin
      verdict = VERDICT_ACK;
    end else begin
      verdict = VERDICT_NOFLAG;
    end
  end

  assign pvalid = (verdict == VERDICT_ACK) && (hdr_end < size);

  assign result.verdict        = verdict;
  assign result.handled        = (verdict >= VERDICT_BAD_PORT);
  assign result.source_port    = (verdict >= VERDICT_SYN) ? frame.src_port_seen : 16'd0;
  assign result.payload_valid  = pvalid;
  assign result.payload_start  = pvalid ? hdr_end[15:0] : 16'd0;
  assign result.payload_length = pvalid ? pay_len[15:0] : 16'd0;

endmodule
`default_nettype wire

// ===== hdl/tcp_frame_classifier.sv =====
// TCP frame classifier, top level.
// Byte stream in (in_*), one verdict beat per frame out (out_*), APB registers (cfg_*).
// Frames enter one byte per in_ beat; in_tlast marks the final byte of a frame.
// Each frame starts with lead_in_bytes of lead-in, then Ethernet, IPv4 and TCP headers.
// On the last byte one result beat leaves on out_; other bytes cause no output.
// After its last byte is accepted, the byte waits in the input register, then the capture
// and verdict logic load the result register, from which the result leaves on out_.
// Throughput: one byte per cycle, with no gap between frames, while results are taken.
// A finished result waits in the output register while the next frame's bytes keep
// flowing; only a last byte stalls, and only while the previous result is not taken.
// in_tready falls only in that case, so a stalled receiver stops input at the next frame end.
// Reset (rst_n low, synchronous) clears the byte count, the captured fields and both
// pipeline stages, and restores local_ip 0, service_port 6379, lead_in_bytes 10.
// Registers: 0x0 local_ip, 0x4 service_port, 0x8 lead_in_bytes; write them only while idle.
// The byte count saturates at 2**COUNT_BITS-1.
`default_nettype none
`include "tcp_frame_classifier_defines.svh"
module tcp_frame_classifier
  import tfc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] frame_byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  // out_tdata: [15:0] source_port, [31:16] payload_start, [47:32] payload_length
  // out_tuser: [3:0] verdict, [4] handled, [5] payload_valid
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,
  output logic      [5:0]  out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  cfg_t                  cfg;
  frame_t                frame;
  logic [COUNT_BITS-1:0] frame_len;
  result_t               result, out_res_r;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r, out_valid_nxt;
  logic       advance, take;

  assign cfg_pready = 1'b1;

  tfc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg_o   (cfg)
  );

  // a byte that ends no frame always moves on; a last byte needs a free result slot
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && in_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance && in_last_r) begin
      out_res_r <= result;
    end
  end

  tfc_capture #(
    .COUNT_BITS (COUNT_BITS)
  ) u_capture (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .frame_byte    (in_byte_r),
    .last_byte     (in_last_r),
    .lead_in_bytes (cfg.lead_in_bytes),
    .frame_o       (frame),
    .count_o       (frame_len)
  );

  tfc_verdict #(
    .COUNT_BITS (COUNT_BITS)
  ) u_verdict (
    .cfg       (cfg),
    .frame     (frame),
    .frame_len (frame_len),
    .result    (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.payload_length, out_res_r.payload_start,
                       out_res_r.source_port};
  assign out_tuser  = {out_res_r.payload_valid, out_res_r.handled, out_res_r.verdict};

  `TFC_ASSERT_IMP(a_handled_match, out_valid_r,
    out_res_r.handled == (out_res_r.verdict >= VERDICT_BAD_PORT), "handled flag mismatch")
  `TFC_ASSERT_IMP(a_payload_ack, out_valid_r && out_res_r.payload_valid,
    out_res_r.verdict == VERDICT_ACK, "payload reported for non-ack verdict")
  `TFC_ASSERT_IMP(a_sport_zero, out_valid_r && (out_res_r.verdict < VERDICT_SYN),
    out_res_r.source_port == 16'd0, "source port set for rejected frame")
  `TFC_ASSERT_NXT(a_last_gives_result, advance && in_last_r,
    out_valid_r, "last byte produced no result")
  `TFC_ASSERT_IMP(a_stall_cause, !in_tready,
    in_valid_r && in_last_r && out_valid_r && !out_tready, "input stalled without cause")

endmodule
`default_nettype wire
